### design/bnms_pkg.sv
// Shared constants and controller/datapath interface types for box NMS.
`default_nettype none
package bnms_pkg;

   localparam int MAX_BOXES_DEF  = 64;
   localparam int COORD_BITS_DEF = 12;
   localparam int LABEL_W        = 8;
   localparam int CONF_W         = 16;
   localparam int THR_W          = 17;
   localparam int FRAC_W         = 16;
   localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

   // wait from capturing box B until the overlap verdict is registered
   localparam int WAIT_W = 3;
   localparam logic [WAIT_W-1:0] EVAL_WAIT = 3'd4;

   typedef struct packed {
      logic wr_box;     // store the accepted input box
      logic ord_rd;     // read order memory at idx
      logic box_rd;     // read box memories
      logic box_sel_ord;// box address from order read data, else idx
      logic cap_i;      // hold confidence of box i
      logic rank_clr;
      logic rank_step;  // count box j if it sorts ahead of box i
      logic j_lt_i;
      logic ord_wr;     // order[rank] = idx
      logic cap_a;      // hold geometry of the suppressing box
      logic cap_b;      // hold geometry of the candidate box
      logic mark;       // flag idx suppressed when the overlap test hits
      logic ls_step;    // track last unsuppressed position
      logic emit;       // load the result register
      logic clear;      // end of set
   } cmd_type;

   typedef struct packed {
      logic sup_idx;    // suppression mark at idx
      logic rsp_free;   // result register can take a new transaction
   } status_type;

endpackage
`default_nettype wire

### design/box_non_max_suppression.sv
// Box non-maximum suppression: top level joining controller and datapath.
//
// Boxes arrive on the req_ channel, one transaction per cycle while req_stall
// is low, and are stored until a transaction with req_last_box set. Boxes
// past MAX_BOXES are dropped and flagged on rsp_overflow for that set. The set
// is then ranked by descending confidence (ties in arrival order), suppressed
// greedily by IoU against csr_wr_data's threshold, and the surviving boxes
// leave on rsp_ in ranked order, rsp_last_kept on the final one.
// Work for N stored boxes runs in phases: loading; ranking over the single box
// memory read port; suppression, with memory reads and then the 4-stage overlap
// pipeline for each compared pair; last-survivor scan; output of the kept boxes.
// req_stall is high from the last box until the set is closed. The result
// register takes the next transaction while the previous one is taken;
// rsp_stall only holds the output sequence. Reset (synchronous) empties the
// set, clears rsp_valid and sets the threshold to 0.5. The user must write the
// threshold only while the block is idle; the block itself does not enforce it.
`default_nettype none
module box_non_max_suppression
   import bnms_pkg::*;
#(
   parameter int MAX_BOXES  = MAX_BOXES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [THR_W-1:0]      csr_wr_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_BITS-1:0] req_box_x,
   input  wire logic [COORD_BITS-1:0] req_box_y,
   input  wire logic [COORD_BITS-1:0] req_box_width,
   input  wire logic [COORD_BITS-1:0] req_box_height,
   input  wire logic [LABEL_W-1:0]    req_class_label,
   input  wire logic [CONF_W-1:0]     req_box_confidence,
   input  wire logic                  req_last_box,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COORD_BITS-1:0]      rsp_kept_x,
   output logic [COORD_BITS-1:0]      rsp_kept_y,
   output logic [COORD_BITS-1:0]      rsp_kept_width,
   output logic [COORD_BITS-1:0]      rsp_kept_height,
   output logic [LABEL_W-1:0]         rsp_kept_label,
   output logic [CONF_W-1:0]          rsp_kept_confidence,
   output logic                       rsp_overflow,
   output logic                       rsp_last_kept
);

   localparam int IDX_W = $clog2(MAX_BOXES);
   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   cmd_type          cmd;
   status_type       status;
   logic [IDX_W-1:0] idx;
   logic [CNT_W-1:0] count;

   bnms_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_box (req_last_box),
      .req_stall    (req_stall),
      .status       (status),
      .count        (count),
      .cmd          (cmd),
      .idx          (idx)
   );

   bnms_dp #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .idx                 (idx),
      .status              (status),
      .count               (count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_box_x           (req_box_x),
      .req_box_y           (req_box_y),
      .req_box_width       (req_box_width),
      .req_box_height      (req_box_height),
      .req_class_label     (req_class_label),
      .req_box_confidence  (req_box_confidence),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kept_x          (rsp_kept_x),
      .rsp_kept_y          (rsp_kept_y),
      .rsp_kept_width      (rsp_kept_width),
      .rsp_kept_height     (rsp_kept_height),
      .rsp_kept_label      (rsp_kept_label),
      .rsp_kept_confidence (rsp_kept_confidence),
      .rsp_overflow        (rsp_overflow),
      .rsp_last_kept       (rsp_last_kept)
   );

endmodule
`default_nettype wire

### design/bnms_dp.sv
// Datapath: box stores, order memory, rank counter, overlap pipeline, result register.
`default_nettype none
module bnms_dp
   import bnms_pkg::*;
#(
   parameter int MAX_BOXES  = MAX_BOXES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_BOXES),
   localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire logic [IDX_W-1:0]      idx,
   output status_type                 status,
   output logic [CNT_W-1:0]           count,
   input  wire logic                  csr_wr_en,
   input  wire logic [THR_W-1:0]      csr_wr_data,
   input  wire logic [COORD_BITS-1:0] req_box_x,
   input  wire logic [COORD_BITS-1:0] req_box_y,
   input  wire logic [COORD_BITS-1:0] req_box_width,
   input  wire logic [COORD_BITS-1:0] req_box_height,
   input  wire logic [LABEL_W-1:0]    req_class_label,
   input  wire logic [CONF_W-1:0]     req_box_confidence,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COORD_BITS-1:0]      rsp_kept_x,
   output logic [COORD_BITS-1:0]      rsp_kept_y,
   output logic [COORD_BITS-1:0]      rsp_kept_width,
   output logic [COORD_BITS-1:0]      rsp_kept_height,
   output logic [LABEL_W-1:0]         rsp_kept_label,
   output logic [CONF_W-1:0]          rsp_kept_confidence,
   output logic                       rsp_overflow,
   output logic                       rsp_last_kept
);

   localparam int C      = COORD_BITS;
   localparam int GEO_W  = 4 * C;
   localparam int SC_W   = LABEL_W + CONF_W;
   localparam int SIDE_W = C + 1;
   localparam int AREA_W = 2 * C + 2;
   localparam int UNI_W  = 2 * C + 3;
   localparam int PROD_W = UNI_W + THR_W;

   logic [GEO_W-1:0] geo_mem [MAX_BOXES];
   logic [SC_W-1:0]  sc_mem  [MAX_BOXES];
   logic [IDX_W-1:0] ord_mem [MAX_BOXES];

   logic [GEO_W-1:0] geo_rd_ff;
   logic [SC_W-1:0]  sc_rd_ff;
   logic [IDX_W-1:0] ord_rd_ff;
   logic [IDX_W-1:0] box_addr;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 dropped_ff, dropped_in;
   logic [MAX_BOXES-1:0] sup_ff, sup_in;
   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [CONF_W-1:0]    conf_i_ff;
   logic [IDX_W-1:0]     rank_ff, rank_in;
   logic [IDX_W-1:0]     last_ff;
   logic [GEO_W-1:0]     a_ff, b_ff;

   logic [SIDE_W-1:0] ix, iy, ix_ff, iy_ff;
   logic [AREA_W-1:0] area_a_ff, area_b_ff, inter_ff, asum_ff;
   logic [UNI_W-1:0]  uni_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              hit;

   logic rsp_valid_ff, rsp_valid_in;
   logic room;

   assign room     = count_ff < CNT_W'(MAX_BOXES);
   assign box_addr = cmd.box_sel_ord ? ord_rd_ff : idx;

   // memories
   always_ff @(posedge clock) begin
      if (cmd.wr_box && room) begin
         geo_mem[count_ff[IDX_W-1:0]] <= {req_box_x, req_box_y, req_box_width, req_box_height};
         sc_mem[count_ff[IDX_W-1:0]]  <= {req_class_label, req_box_confidence};
      end
      if (cmd.box_rd) begin
         geo_rd_ff <= geo_mem[box_addr];
         sc_rd_ff  <= sc_mem[box_addr];
      end
      if (cmd.ord_wr) begin
         ord_mem[rank_ff] <= idx;
      end
      if (cmd.ord_rd) begin
         ord_rd_ff <= ord_mem[idx];
      end
   end

   // set bookkeeping
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      sup_in     = sup_ff;
      thr_in     = thr_ff;
      if (cmd.wr_box) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.mark && hit) begin
         sup_in[idx] = 1'b1;
      end
      if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
         sup_in     = '0;
      end
      if (csr_wr_en) begin
         thr_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         sup_ff     <= '0;
         thr_ff     <= THR_RESET;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         sup_ff     <= sup_in;
         thr_ff     <= thr_in;
      end
   end

   // ranking: position = boxes with higher confidence, or equal and earlier
   always_comb begin
      rank_in = rank_ff;
      if (cmd.rank_clr) begin
         rank_in = '0;
      end else if (cmd.rank_step) begin
         if (sc_rd_ff[CONF_W-1:0] > conf_i_ff ||
             (sc_rd_ff[CONF_W-1:0] == conf_i_ff && cmd.j_lt_i)) begin
            rank_in = rank_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
      if (cmd.cap_i) begin
         conf_i_ff <= sc_rd_ff[CONF_W-1:0];
      end
      if (cmd.cap_a) begin
         a_ff <= geo_rd_ff;
      end
      if (cmd.cap_b) begin
         b_ff <= geo_rd_ff;
      end
      if (cmd.ls_step && !sup_ff[idx]) begin
         last_ff <= idx;
      end
   end

   // overlap side with the +1 pixel convention, zero when disjoint
   function automatic logic [SIDE_W-1:0] side_overlap(
      input logic [C-1:0] pa, input logic [C-1:0] la,
      input logic [C-1:0] pb, input logic [C-1:0] lb);
      logic [C:0]   ea, eb, hi;
      logic [C-1:0] lo;
      logic [C+1:0] hi1;
      logic [C+1:0] diff;
      ea  = {1'b0, pa} + {1'b0, la};
      eb  = {1'b0, pb} + {1'b0, lb};
      hi  = (ea < eb) ? ea : eb;
      lo  = (pa > pb) ? pa : pb;
      hi1 = {1'b0, hi} + (C+2)'(1);
      diff = hi1 - {2'b00, lo};
      return (hi1 > {2'b00, lo}) ? diff[SIDE_W-1:0] : '0;
   endfunction

   assign ix = side_overlap(a_ff[4*C-1:3*C], a_ff[2*C-1:C], b_ff[4*C-1:3*C], b_ff[2*C-1:C]);
   assign iy = side_overlap(a_ff[3*C-1:2*C], a_ff[C-1:0], b_ff[3*C-1:2*C], b_ff[C-1:0]);

   // free-running overlap pipeline: area, intersection and threshold multiplies
   always_ff @(posedge clock) begin
      ix_ff     <= ix;
      iy_ff     <= iy;
      area_a_ff <= ({1'b0, a_ff[2*C-1:C]} + SIDE_W'(1)) * ({1'b0, a_ff[C-1:0]} + SIDE_W'(1));
      area_b_ff <= ({1'b0, b_ff[2*C-1:C]} + SIDE_W'(1)) * ({1'b0, b_ff[C-1:0]} + SIDE_W'(1));
      inter_ff  <= AREA_W'(ix_ff) * AREA_W'(iy_ff);
      asum_ff   <= area_a_ff + area_b_ff;
      uni_ff    <= {1'b0, asum_ff} - {1'b0, inter_ff};
      prod_ff   <= PROD_W'(thr_ff) * PROD_W'(uni_ff);
   end

   assign hit = PROD_W'({inter_ff, {FRAC_W{1'b0}}}) > prod_ff;

   // result register
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign status.sup_idx  = sup_ff[idx];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         {rsp_kept_x, rsp_kept_y, rsp_kept_width, rsp_kept_height} <= geo_rd_ff;
         {rsp_kept_label, rsp_kept_confidence} <= sc_rd_ff;
         rsp_overflow  <= dropped_ff;
         rsp_last_kept <= (idx == last_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign count     = count_ff;

endmodule
`default_nettype wire

### design/bnms_ctrl.sv
// Controller: load, rank sort, greedy suppression, output sequencing.
`default_nettype none
module bnms_ctrl
   import bnms_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF,
   localparam int IDX_W = $clog2(MAX_BOXES),
   localparam int CNT_W = $clog2(MAX_BOXES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last_box,
   output logic                  req_stall,
   input  wire status_type       status,
   input  wire logic [CNT_W-1:0] count,
   output cmd_type               cmd,
   output logic [IDX_W-1:0]      idx
);

   localparam logic [4:0] ST_LOAD  = 5'd0;
   localparam logic [4:0] ST_RK_I  = 5'd1;
   localparam logic [4:0] ST_RK_CI = 5'd2;
   localparam logic [4:0] ST_RK_J  = 5'd3;
   localparam logic [4:0] ST_RK_CJ = 5'd4;
   localparam logic [4:0] ST_RK_W  = 5'd5;
   localparam logic [4:0] ST_SP_I  = 5'd6;
   localparam logic [4:0] ST_SP_OA = 5'd7;
   localparam logic [4:0] ST_SP_GA = 5'd8;
   localparam logic [4:0] ST_SP_J  = 5'd9;
   localparam logic [4:0] ST_SP_OB = 5'd10;
   localparam logic [4:0] ST_SP_GB = 5'd11;
   localparam logic [4:0] ST_SP_EV = 5'd12;
   localparam logic [4:0] ST_LS    = 5'd13;
   localparam logic [4:0] ST_OUT_I = 5'd14;
   localparam logic [4:0] ST_OUT_O = 5'd15;
   localparam logic [4:0] ST_OUT_G = 5'd16;
   localparam logic [4:0] ST_DONE  = 5'd17;

   logic [4:0]        state_ff, state_in;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [IDX_W-1:0]  n_last;
   logic              use_j;

   assign n_last    = IDX_W'(count - CNT_W'(1));
   assign req_stall = (state_ff != ST_LOAD);
   assign use_j     = (state_ff == ST_RK_J) || (state_ff == ST_RK_CJ) ||
                      (state_ff == ST_SP_J) || (state_ff == ST_SP_OB) ||
                      (state_ff == ST_SP_GB) || (state_ff == ST_SP_EV);
   assign idx       = use_j ? j_ff : i_ff;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      wait_in  = wait_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            i_in = '0;
            if (req_valid) begin
               cmd.wr_box = 1'b1;
               if (req_last_box) begin
                  state_in = ST_RK_I;
               end
            end
         end
         ST_RK_I: begin
            cmd.box_rd = 1'b1;
            state_in   = ST_RK_CI;
         end
         ST_RK_CI: begin
            cmd.cap_i    = 1'b1;
            cmd.rank_clr = 1'b1;
            j_in         = '0;
            state_in     = ST_RK_J;
         end
         ST_RK_J: begin
            cmd.box_rd = 1'b1;
            state_in   = ST_RK_CJ;
         end
         ST_RK_CJ: begin
            cmd.rank_step = 1'b1;
            cmd.j_lt_i    = (j_ff < i_ff);
            if (j_ff == n_last) begin
               state_in = ST_RK_W;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_RK_J;
            end
         end
         ST_RK_W: begin
            cmd.ord_wr = 1'b1;
            if (i_ff == n_last) begin
               i_in     = '0;
               state_in = ST_SP_I;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_RK_I;
            end
         end
         ST_SP_I: begin
            if (i_ff == n_last) begin
               i_in     = '0;
               state_in = ST_LS;
            end else if (status.sup_idx) begin
               i_in = i_ff + IDX_W'(1);
            end else begin
               cmd.ord_rd = 1'b1;
               state_in   = ST_SP_OA;
            end
         end
         ST_SP_OA: begin
            cmd.box_rd      = 1'b1;
            cmd.box_sel_ord = 1'b1;
            state_in        = ST_SP_GA;
         end
         ST_SP_GA: begin
            cmd.cap_a = 1'b1;
            j_in      = i_ff + IDX_W'(1);
            state_in  = ST_SP_J;
         end
         ST_SP_J: begin
            cmd.ord_rd = 1'b1;
            state_in   = ST_SP_OB;
         end
         ST_SP_OB: begin
            cmd.box_rd      = 1'b1;
            cmd.box_sel_ord = 1'b1;
            state_in        = ST_SP_GB;
         end
         ST_SP_GB: begin
            cmd.cap_b = 1'b1;
            wait_in   = '0;
            state_in  = ST_SP_EV;
         end
         ST_SP_EV: begin
            if (wait_ff == EVAL_WAIT) begin
               cmd.mark = 1'b1;
               if (j_ff == n_last) begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_SP_I;
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = ST_SP_J;
               end
            end else begin
               wait_in = wait_ff + WAIT_W'(1);
            end
         end
         ST_LS: begin
            cmd.ls_step = 1'b1;
            if (i_ff == n_last) begin
               i_in     = '0;
               state_in = ST_OUT_I;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         ST_OUT_I: begin
            if (status.sup_idx) begin
               if (i_ff == n_last) begin
                  state_in = ST_DONE;
               end else begin
                  i_in = i_ff + IDX_W'(1);
               end
            end else begin
               cmd.ord_rd = 1'b1;
               state_in   = ST_OUT_O;
            end
         end
         ST_OUT_O: begin
            cmd.box_rd      = 1'b1;
            cmd.box_sel_ord = 1'b1;
            state_in        = ST_OUT_G;
         end
         ST_OUT_G: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (i_ff == n_last) begin
                  state_in = ST_DONE;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_OUT_I;
               end
            end
         end
         ST_DONE: begin
            cmd.clear = 1'b1;
            state_in  = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         i_ff     <= '0;
         j_ff     <= '0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         wait_ff  <= wait_in;
      end
   end

endmodule
`default_nettype wire

### design/bnms_chk.sv
// Port-level checker for box NMS, bound to the top level.
`default_nettype none
module bnms_chk
   import bnms_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [COORD_BITS-1:0] rsp_kept_x,
   input wire logic [CONF_W-1:0]     rsp_kept_confidence,
   input wire logic                  rsp_overflow,
   input wire logic                  rsp_last_kept
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kept_x) &&
      $stable(rsp_kept_confidence) && $stable(rsp_last_kept))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

   // while a set is still being emitted no new box is taken
   a_no_load_mid_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_kept |-> req_stall)
      else $error("input taken during output of a set");

   // overflow is one value for the whole set
   a_overflow_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_kept |=> $stable(rsp_overflow))
      else $error("overflow changed within a set");

endmodule

bind box_non_max_suppression bnms_chk #(.COORD_BITS(COORD_BITS)) u_bnms_chk (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_kept_x          (rsp_kept_x),
   .rsp_kept_confidence (rsp_kept_confidence),
   .rsp_overflow        (rsp_overflow),
   .rsp_last_kept       (rsp_last_kept)
);
`default_nettype wire

### dv/box_nms_checker.sv
// Checker for box_non_max_suppression: watches both channels, predicts kept boxes, compares.
module box_nms_checker
   import bnms_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [THR_W-1:0]          csr_wr_data,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [COORD_BITS_DEF-1:0] req_box_x,
   input  logic [COORD_BITS_DEF-1:0] req_box_y,
   input  logic [COORD_BITS_DEF-1:0] req_box_width,
   input  logic [COORD_BITS_DEF-1:0] req_box_height,
   input  logic [LABEL_W-1:0]        req_class_label,
   input  logic [CONF_W-1:0]         req_box_confidence,
   input  logic                      req_last_box,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [COORD_BITS_DEF-1:0] rsp_kept_x,
   input  logic [COORD_BITS_DEF-1:0] rsp_kept_y,
   input  logic [COORD_BITS_DEF-1:0] rsp_kept_width,
   input  logic [COORD_BITS_DEF-1:0] rsp_kept_height,
   input  logic [LABEL_W-1:0]        rsp_kept_label,
   input  logic [CONF_W-1:0]         rsp_kept_confidence,
   input  logic                      rsp_overflow,
   input  logic                      rsp_last_kept,
   output int                        fail_count,
   output int                        kept_pending,
   output int                        sets_closed,
   output int                        kept_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COORD_BITS_DEF-1:0] x, y, w, h;
      logic [LABEL_W-1:0]        label;
      logic [CONF_W-1:0]         conf;
   } box_t;

   typedef struct packed {
      box_t bx;
      logic overflow;
      logic last_kept;
   } kept_t;

   box_t             loaded_boxes[$];
   bit               boxes_dropped;
   logic [THR_W-1:0] iou_thr;
   kept_t            kept_boxes[$];
   int               errors, n_sets, n_kept;

   // exact IoU test with the +1 pixel convention
   function automatic bit too_much_overlap(box_t a, box_t b, logic [THR_W-1:0] thr);
      longint ix, iy, inter, uni, lo, hi;
      hi = (a.x + 64'(a.w) < b.x + 64'(b.w)) ? a.x + 64'(a.w) : b.x + 64'(b.w);
      lo = (a.x > b.x) ? a.x : b.x;
      ix = hi - lo + 1;
      hi = (a.y + 64'(a.h) < b.y + 64'(b.h)) ? a.y + 64'(a.h) : b.y + 64'(b.h);
      lo = (a.y > b.y) ? a.y : b.y;
      iy = hi - lo + 1;
      if (ix < 0) ix = 0;
      if (iy < 0) iy = 0;
      inter = ix * iy;
      uni = (longint'(a.w) + 1) * (longint'(a.h) + 1)
          + (longint'(b.w) + 1) * (longint'(b.h) + 1) - inter;
      return inter * 65536 > longint'(thr) * uni;
   endfunction

   function automatic void resolve_set();
      int    ranked[$];
      bit    gone[MAX_BOXES_DEF];
      int    k, final_pos, n;
      kept_t e;
      n = loaded_boxes.size();
      // stable insertion by descending confidence
      for (int i = 0; i < n; i++) begin
         k = ranked.size();
         ranked.insert(ranked.size(), i);
         while (k > 0 && loaded_boxes[ranked[k-1]].conf < loaded_boxes[i].conf) begin
            ranked[k] = ranked[k-1];
            k--;
         end
         ranked[k] = i;
      end
      for (int i = 0; i < n; i++) begin
         if (!gone[i]) begin
            for (int j = i + 1; j < n; j++)
               if (too_much_overlap(loaded_boxes[ranked[i]], loaded_boxes[ranked[j]], iou_thr))
                  gone[j] = 1;
         end
      end
      final_pos = 0;
      for (int i = 0; i < n; i++)
         if (!gone[i]) final_pos = i;
      for (int i = 0; i < n; i++) begin
         if (!gone[i]) begin
            e.bx        = loaded_boxes[ranked[i]];
            e.overflow  = boxes_dropped;
            e.last_kept = (i == final_pos);
            kept_boxes.insert(kept_boxes.size(), e);
         end
      end
      loaded_boxes.delete();
      boxes_dropped = 0;
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      kept_t e;
      box_t  b;
      if (reset) begin
         loaded_boxes.delete();
         kept_boxes.delete();
         boxes_dropped = 0;
         iou_thr = THR_RESET;
      end else begin
         if (csr_wr_en) iou_thr = csr_wr_data;
         if (req_valid && !req_stall) begin
            b = '{req_box_x, req_box_y, req_box_width, req_box_height,
                  req_class_label, req_box_confidence};
            if (loaded_boxes.size() < MAX_BOXES_DEF)
               loaded_boxes.insert(loaded_boxes.size(), b);
            else boxes_dropped = 1;
            if (req_last_box) begin
               resolve_set();
               n_sets++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (kept_boxes.size() == 0) begin
               $error("kept box transaction with nothing expected");
               errors++;
            end else begin
               e = kept_boxes.pop_front();
               check_field("kept_x", e.bx.x, rsp_kept_x);
               check_field("kept_y", e.bx.y, rsp_kept_y);
               check_field("kept_width", e.bx.w, rsp_kept_width);
               check_field("kept_height", e.bx.h, rsp_kept_height);
               check_field("kept_label", e.bx.label, rsp_kept_label);
               check_field("kept_confidence", e.bx.conf, rsp_kept_confidence);
               check_field("overflow", e.overflow, rsp_overflow);
               check_field("last_kept", e.last_kept, rsp_last_kept);
               n_kept++;
            end
         end
      end
      fail_count   <= errors;
      kept_pending <= kept_boxes.size();
      sets_closed  <= n_sets;
      kept_checked <= n_kept;
   end
endmodule

### dv/tb.sv
// Testbench top for box_non_max_suppression: stimulus, idling, pressure and verdict.
module tb
   import bnms_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic                      clock, reset;
   logic                      csr_wr_en;
   logic [THR_W-1:0]          csr_wr_data;
   logic                      req_valid, req_stall;
   logic [COORD_BITS_DEF-1:0] req_box_x, req_box_y, req_box_width, req_box_height;
   logic [LABEL_W-1:0]        req_class_label;
   logic [CONF_W-1:0]         req_box_confidence;
   logic                      req_last_box;
   logic                      rsp_valid, rsp_stall;
   logic [COORD_BITS_DEF-1:0] rsp_kept_x, rsp_kept_y, rsp_kept_width, rsp_kept_height;
   logic [LABEL_W-1:0]        rsp_kept_label;
   logic [CONF_W-1:0]         rsp_kept_confidence;
   logic                      rsp_overflow, rsp_last_kept;

   int fail_count, kept_pending, sets_closed, kept_checked;
   int send_idle_pct, recv_stall_pct, hold_left;

   box_non_max_suppression dut (.*);

   box_nms_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // receiver stall, with an optional long hold for back-pressure
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_box(logic [11:0] x, y, w, h, logic [7:0] label,
                           logic [15:0] conf, logic last_flag);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_box_x = x;
      req_box_y = y;
      req_box_width = w;
      req_box_height = h;
      req_class_label = label;
      req_box_confidence = conf;
      req_last_box = last_flag;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 0;
      while (kept_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] thr);
      settle();
      @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = thr;
      @(negedge clock);
      csr_wr_en = 0;
   endtask

   // clustered boxes so that overlaps are common; some fully random
   task automatic send_random_set(int n);
      logic [11:0] bx, by;
      logic [15:0] conf;
      bx = 12'($urandom);
      by = 12'($urandom);
      conf = 16'($urandom);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(3) != 0) conf = 16'($urandom);
         if ($urandom_range(9) == 0)
            send_box(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                     8'($urandom), conf, i == n - 1);
         else
            send_box(bx + 12'($urandom_range(40)), by + 12'($urandom_range(40)),
                     12'($urandom_range(80)), 12'($urandom_range(80)), 8'($urandom),
                     conf, i == n - 1);
      end
   endtask

   initial begin
      logic [THR_W-1:0] thr_plan[5];
      reset = 1;
      csr_wr_en = 0;
      csr_wr_data = 0;
      req_valid = 0;
      req_box_x = 0;
      req_box_y = 0;
      req_box_width = 0;
      req_box_height = 0;
      req_class_label = 0;
      req_box_confidence = 0;
      req_last_box = 0;
      rsp_stall = 0;
      hold_left = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed, at reset threshold 0.5
      send_box(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 16'hFFFF, 1'b1);
      send_box(12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 16'd0, 1'b1);
      // equal confidences: ties keep arrival order, duplicates suppressed
      send_box(12'd100, 12'd100, 12'd20, 12'd20, 8'd1, 16'h8000, 1'b0);
      send_box(12'd100, 12'd100, 12'd20, 12'd20, 8'd2, 16'h8000, 1'b0);
      send_box(12'd300, 12'd300, 12'd5, 12'd5, 8'd3, 16'h8000, 1'b1);
      // nested and lower-scored boxes, reversed arrival order
      send_box(12'd50, 12'd50, 12'd10, 12'd10, 8'd4, 16'd100, 1'b0);
      send_box(12'd48, 12'd48, 12'd14, 12'd14, 8'd5, 16'd200, 1'b0);
      send_box(12'd0, 12'd0, 12'd4095, 12'd4095, 8'd6, 16'd300, 1'b0);
      send_box(12'd4000, 12'd10, 12'd0, 12'd0, 8'd7, 16'd50, 1'b1);
      thr_plan = '{17'd0, 17'd65536, 17'd65535, 17'd16384, 17'd32768};
      foreach (thr_plan[p]) begin
         write_threshold(p == 3 ? 17'($urandom_range(65536)) : thr_plan[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         if (p == 0) begin
            // coincident and disjoint zero-size boxes under the zero threshold
            send_box(12'd10, 12'd10, 12'd0, 12'd0, 8'd8, 16'd9, 1'b0);
            send_box(12'd10, 12'd10, 12'd0, 12'd0, 8'd9, 16'd9, 1'b0);
            send_box(12'd12, 12'd10, 12'd0, 12'd0, 8'd10, 16'd9, 1'b1);
         end
         if (p == 1) hold_left = 400;
         for (int s = 0; s < 2; s++) send_random_set($urandom_range(1, 5));
         if (p == 4) begin
            // more boxes than fit, the marked final one among the dropped
            send_idle_pct = 0;
            recv_stall_pct = 20;
            send_random_set(MAX_BOXES_DEF + 2);
         end
      end
      settle();
      $display("Closed %0d box sets and checked %0d kept boxes", sets_closed, kept_checked);
      $display("across five thresholds including 0, 65535 and 65536, with overflow and stalls");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end
endmodule
